// File: rtl/core/packed_palette_index_unpacker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packed palette index unpacker
// Concurrent assertion helpers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PACKED_PALETTE_INDEX_UNPACKER_DEFINES_SVH
`define PACKED_PALETTE_INDEX_UNPACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PPIU_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define PPIU_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PPIU_ASSERT_IMP(name, clk, rstn, ante, cons)
`define PPIU_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/ppiu_pkg.sv
// ----------------------------------------------------------------------------
// Packed palette index unpacker package
// Shared constants, result types and the width and slot decode functions.
// ----------------------------------------------------------------------------
package ppiu_pkg;

  localparam int unsigned WordBits        = 64;
  localparam int unsigned MinWidth        = 4;
  localparam int unsigned MaxWidth        = 12;
  localparam int unsigned IdxW            = 12;
  localparam int unsigned NodeW           = 12;
  localparam int unsigned CfgW            = 13;
  localparam int unsigned WidthW          = 4;
  localparam int unsigned SlotW           = 5;
  localparam int unsigned DefSectionNodes = 4096;

  // Decoded index geometry: field width and fields per word.
  typedef struct packed {
    logic [WidthW-1:0] width;
    logic [SlotW-1:0]  slots;
  } geom_t;

  // One result transaction.
  typedef struct packed {
    logic [IdxW-1:0]  entry_index;
    logic [NodeW-1:0] node_number;
    logic             last_of_word;
    logic             last_of_section;
  } res_t;

  // Bit length of (size - 1), clamped to the range MinWidth..MaxWidth.
  function automatic logic [WidthW-1:0] index_width(logic [CfgW-1:0] size);
    logic [CfgW-1:0]   n;
    logic [WidthW-1:0] w;
    n = size - CfgW'(1);
    w = WidthW'(MinWidth);
    if (size > CfgW'(1)) begin
      for (int b = 0; b < CfgW; b++) begin
        if (n[b]) begin
          w = WidthW'(b + 1);
        end
      end
    end
    if (w < WidthW'(MinWidth)) begin
      w = WidthW'(MinWidth);
    end
    if (w > WidthW'(MaxWidth)) begin
      w = WidthW'(MaxWidth);
    end
    return w;
  endfunction

  // Number of whole fields of the given width in one word.
  function automatic logic [SlotW-1:0] word_slots(logic [WidthW-1:0] width);
    logic [SlotW-1:0] s;
    unique case (width)
      4'd4:    s = SlotW'(WordBits / 4);
      4'd5:    s = SlotW'(WordBits / 5);
      4'd6:    s = SlotW'(WordBits / 6);
      4'd7:    s = SlotW'(WordBits / 7);
      4'd8:    s = SlotW'(WordBits / 8);
      4'd9:    s = SlotW'(WordBits / 9);
      4'd10:   s = SlotW'(WordBits / 10);
      4'd11:   s = SlotW'(WordBits / 11);
      4'd12:   s = SlotW'(WordBits / 12);
      default: s = SlotW'(WordBits / MinWidth);
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/packed_palette_index_unpacker.sv
// ----------------------------------------------------------------------------
// Packed palette index unpacker
// Splits 64-bit packed words into palette indices, one index per transaction.
// ----------------------------------------------------------------------------
// Each slave transaction carries one 64-bit word of a packed index array. The
// block emits one master transaction per index field in that word, lowest
// field first. The field width follows the palette entry count register: the
// bit length of (entry count - 1), at least 4 and at most 12 bits.
// The configuration port takes a new entry count whenever cfg_we_i is high;
// it should only be written while no word is in flight.
// The first index of a word passes the input word register of the slicer and
// then the result register before it is valid on the master side.
// A word then yields one index per field it holds (16 at 4-bit fields down
// to 5 at 12-bit fields, fewer when a section ends inside it), and the next
// word is accepted in the same cycle the last field of the current word
// moves on, so the slicer issues one index every cycle while words keep
// coming and the receiver keeps up.
// When the node counter reaches the final node of a section, the remaining
// fields of that word are dropped, the result carries both last flags and the
// counter wraps to zero.
// Reset clears the counter, empties both registers and restores an entry
// count of 2 (4-bit fields). When the receiver stalls, the result register
// holds its transaction; the slicer then stops, and s_axis_tready falls.
// ----------------------------------------------------------------------------
`include "packed_palette_index_unpacker_defines.svh"

module packed_palette_index_unpacker #(
  parameter int unsigned SectionNodes = ppiu_pkg::DefSectionNodes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: palette entry count.
  input  logic                          cfg_we_i,
  input  logic [ppiu_pkg::CfgW-1:0]     cfg_wdata_i,
  // Slave side. tdata: packed_word[63:0].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ppiu_pkg::WordBits-1:0] s_axis_tdata,
  // Master side. tdata: entry_index[11:0], node_number[23:12].
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,
  // tuser: last_of_word[0].
  output logic                          m_axis_tuser,
  // tlast: last_of_section.
  output logic                          m_axis_tlast
);
  import ppiu_pkg::*;

  geom_t geom;
  res_t  slc_res, out_res;
  logic  slc_valid, slc_ready;

  // Palette size register, kept as decoded width and fields per word.
  ppiu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom)
  );

  // Input word register, field extraction and node counter.
  ppiu_slicer #(
    .SectionNodes (SectionNodes)
  ) u_slicer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .word_valid_i (s_axis_tvalid),
    .word_ready_o (s_axis_tready),
    .word_i       (s_axis_tdata),
    .res_valid_o  (slc_valid),
    .res_ready_i  (slc_ready),
    .res_o        (slc_res)
  );

  // Result register toward the master side.
  ppiu_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (slc_valid),
    .up_ready_o (slc_ready),
    .up_data_i  (slc_res),
    .dn_valid_o (m_axis_tvalid),
    .dn_ready_i (m_axis_tready),
    .dn_data_o  (out_res)
  );

  assign m_axis_tdata = {out_res.node_number, out_res.entry_index};
  assign m_axis_tuser = out_res.last_of_word;
  assign m_axis_tlast = out_res.last_of_section;

  // After the final node of a section leaves the slicer, numbering restarts.
  `PPIU_ASSERT_NXT(a_section_wrap, clk_i, rst_ni,
    slc_valid && slc_ready && slc_res.last_of_section,
    slc_res.node_number == '0)

  // A word is replaced only as the last field of the previous one moves on.
  `PPIU_ASSERT_IMP(a_word_handover, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && slc_valid,
    slc_ready && slc_res.last_of_word)

  // The end of a section always closes the word as well.
  `PPIU_ASSERT_IMP(a_section_closes_word, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tlast,
    m_axis_tuser)

endmodule

// File: rtl/core/ppiu_cfg.sv
// ----------------------------------------------------------------------------
// Palette size register
// Decodes a palette size write into the index width and fields per word.
// ----------------------------------------------------------------------------
module ppiu_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ppiu_pkg::CfgW-1:0] cfg_wdata_i,
  output ppiu_pkg::geom_t          geom_o
);
  import ppiu_pkg::*;

  geom_t geom_d, geom_q;

  // Decode at write time so the datapath sees a registered geometry.
  always_comb begin
    geom_d.width = index_width(cfg_wdata_i);
    geom_d.slots = word_slots(geom_d.width);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.width <= WidthW'(MinWidth);
      geom_q.slots <= SlotW'(WordBits / MinWidth);
    end else if (cfg_we_i) begin
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

// File: rtl/core/ppiu_slicer.sv
// ----------------------------------------------------------------------------
// Word slicer
// Holds one packed word and hands out one index field per transaction.
// ----------------------------------------------------------------------------
module ppiu_slicer #(
  parameter int unsigned SectionNodes = ppiu_pkg::DefSectionNodes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppiu_pkg::geom_t               geom_i,
  input  logic                          word_valid_i,
  output logic                          word_ready_o,
  input  logic [ppiu_pkg::WordBits-1:0] word_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ppiu_pkg::res_t                res_o
);
  import ppiu_pkg::*;

  localparam int unsigned CntW = $clog2(SectionNodes);

  logic                busy_d, busy_q;
  logic [WordBits-1:0] word_d, word_q;
  logic [SlotW-1:0]    slot_d, slot_q;
  logic [CntW-1:0]     cnt_d, cnt_q;
  logic [IdxW-1:0]     mask;
  logic                fire, end_sec, end_word, take;

  assign fire     = busy_q && res_ready_i;
  assign end_sec  = (cnt_q == CntW'(SectionNodes - 1));
  assign end_word = end_sec || (slot_q == (geom_i.slots - SlotW'(1)));
  assign take     = word_valid_i && word_ready_o;
  assign mask     = IdxW'((13'd1 << geom_i.width) - 13'd1);

  // A new word may enter in the cycle that the last field of the old one leaves.
  assign word_ready_o = !busy_q || (fire && end_word);

  always_comb begin
    busy_d = busy_q;
    word_d = word_q;
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (fire) begin
      cnt_d = end_sec ? '0 : cnt_q + CntW'(1);
    end
    if (take) begin
      busy_d = 1'b1;
      word_d = word_i;
      slot_d = '0;
    end else if (fire && end_word) begin
      busy_d = 1'b0;
    end else if (fire) begin
      word_d = word_q >> geom_i.width;
      slot_d = slot_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign res_valid_o           = busy_q;
  assign res_o.entry_index     = word_q[IdxW-1:0] & mask;
  assign res_o.node_number     = NodeW'(cnt_q);
  assign res_o.last_of_word    = end_word;
  assign res_o.last_of_section = end_sec;

endmodule

// File: rtl/core/ppiu_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Registers result transactions so a stalled receiver does not stop the slicer
// until the register is full.
// ----------------------------------------------------------------------------
module ppiu_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           up_valid_i,
  output logic           up_ready_o,
  input  ppiu_pkg::res_t up_data_i,
  output logic           dn_valid_o,
  input  logic           dn_ready_i,
  output ppiu_pkg::res_t dn_data_o
);
  import ppiu_pkg::*;

  logic valid_d, valid_q;
  res_t data_q;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign valid_d    = up_ready_o ? up_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= up_data_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule
